### src/assert_macros.svh
// Assertion macros shared by the voxel grid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define VGNC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define VGNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VGNC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VGNC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/vgnc_pkg.sv
// Types, constants and helpers shared by the voxel grid neighbor counter.
`timescale 1ns / 1ps
package vgnc_pkg;

  // Store geometry
  localparam int MAX_EXTENT = 16;
  localparam int VALUE_BITS = 16;
  localparam int CELL_COUNT = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IDX_W      = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int EXT_W      = $clog2(MAX_EXTENT + 1);
  localparam int HD_W       = 2 * EXT_W;
  localparam int SUM_W      = IDX_W + HD_W + 1;

  // Port field widths
  localparam int CFG_W   = 5;
  localparam int COORD_W = 6;
  localparam int WIDE_W  = COORD_W + 1;

  localparam int NUM_PROBES = 6;

  typedef logic [1:0]                    mode_t;
  typedef logic signed [COORD_W-1:0]     coord_t;
  typedef logic signed [WIDE_W-1:0]      wcoord_t;
  typedef logic signed [15:0]            value_t;
  typedef logic [2:0]                    count_t;
  typedef logic [CFG_W-1:0]              cfg_data_t;
  typedef logic [1:0]                    cfg_index_t;
  typedef logic [EXT_W-1:0]              ext_t;
  typedef logic [HD_W-1:0]               hd_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic signed [VALUE_BITS-1:0]  cell_t;
  typedef logic [2:0]                    probe_t;

  // Item modes
  localparam mode_t MODE_WRITE  = 2'd0;
  localparam mode_t MODE_READ   = 2'd1;
  localparam mode_t MODE_COUNT  = 2'd2;

  // Register indexes
  localparam cfg_index_t REG_GRID_WIDTH  = 2'd0;
  localparam cfg_index_t REG_GRID_HEIGHT = 2'd1;
  localparam cfg_index_t REG_GRID_DEPTH  = 2'd2;

  // Face neighbor order of a count
  localparam probe_t PROBE_X_MINUS = 3'd0;
  localparam probe_t PROBE_X_PLUS  = 3'd1;
  localparam probe_t PROBE_Y_MINUS = 3'd2;
  localparam probe_t PROBE_Y_PLUS  = 3'd3;
  localparam probe_t PROBE_Z_MINUS = 3'd4;
  localparam probe_t PROBE_Z_PLUS  = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_ACCESS,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic   clear;
    logic   load;
    logic   setup;
    logic   access;
    probe_t probe;
    logic   finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic mode_count;
  } sts_t;

  // Extent register values above the store size act as the store size
  function automatic ext_t clamp_extent(cfg_data_t v);
    ext_t r;
    if (int'(v) > MAX_EXTENT) begin
      r = EXT_W'(MAX_EXTENT);
    end else begin
      r = EXT_W'(v);
    end
    return r;
  endfunction

endpackage

### src/vgnc_ifs.sv
// Handshake channel interfaces: input items, result items, register writes.
`timescale 1ns / 1ps
interface vgnc_item_if;
  logic                valid;
  logic                ready;
  vgnc_pkg::mode_t     mode;
  vgnc_pkg::coord_t    coord_x;
  vgnc_pkg::coord_t    coord_y;
  vgnc_pkg::coord_t    coord_z;
  vgnc_pkg::value_t    write_value;
  modport source (output valid, mode, coord_x, coord_y, coord_z, write_value, input ready);
  modport sink (input valid, mode, coord_x, coord_y, coord_z, write_value, output ready);
endinterface

interface vgnc_result_if;
  logic                valid;
  logic                ready;
  vgnc_pkg::value_t    read_value;
  vgnc_pkg::count_t    neighbor_count;
  logic                out_of_range;
  modport source (output valid, read_value, neighbor_count, out_of_range, input ready);
  modport sink (input valid, read_value, neighbor_count, out_of_range, output ready);
endinterface

interface vgnc_cfg_if;
  logic                  valid;
  logic                  ready;
  vgnc_pkg::cfg_index_t  index;
  vgnc_pkg::cfg_data_t   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/vgnc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vgnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/vgnc_ctrl.sv
// Controller state machine: clearing pass, item sequencing, probe counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vgnc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  vgnc_pkg::sts_t  sts,
  output vgnc_pkg::cmd_t  cmd
);

  vgnc_pkg::state_t state;
  vgnc_pkg::state_t state_next;
  vgnc_pkg::probe_t probe;
  vgnc_pkg::probe_t probe_next;
  logic             last_probe;

  // One probe outside count mode, six face neighbors for a count
  assign last_probe = sts.mode_count ? (probe == vgnc_pkg::PROBE_Z_PLUS) : 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    probe_next = probe;
    case (state)
      vgnc_pkg::S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = vgnc_pkg::S_IDLE;
        end
      end
      vgnc_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = vgnc_pkg::S_SETUP;
        end
      end
      vgnc_pkg::S_SETUP: begin
        state_next = vgnc_pkg::S_ACCESS;
        probe_next = vgnc_pkg::PROBE_X_MINUS;
      end
      vgnc_pkg::S_ACCESS: begin
        if (last_probe) begin
          state_next = vgnc_pkg::S_DRAIN;
        end else begin
          probe_next = probe + 3'd1;
        end
      end
      vgnc_pkg::S_DRAIN: begin
        state_next = vgnc_pkg::S_FINISH;
      end
      vgnc_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_next = vgnc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vgnc_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.probe  = probe;
    item_ready = 1'b0;
    case (state)
      vgnc_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      vgnc_pkg::S_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      vgnc_pkg::S_SETUP: begin
        cmd.setup = 1'b1;
      end
      vgnc_pkg::S_ACCESS: begin
        cmd.access = 1'b1;
      end
      vgnc_pkg::S_DRAIN: begin
        cmd.access = 1'b0;
      end
      vgnc_pkg::S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd.access = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vgnc_pkg::S_CLEAR;
      probe <= vgnc_pkg::PROBE_X_MINUS;
    end else begin
      state <= state_next;
      probe <= probe_next;
    end
  end

  `VGNC_ASSERT_NEXT(a_accept_setup, clk, rst, item_valid && item_ready, state == vgnc_pkg::S_SETUP)
  `VGNC_ASSERT_IMPLY(a_probe_range, clk, rst, state == vgnc_pkg::S_ACCESS, probe <= vgnc_pkg::PROBE_Z_PLUS)
  `VGNC_ASSERT_IMPLY(a_single_probe, clk, rst, cmd.access && !sts.mode_count, probe == vgnc_pkg::PROBE_X_MINUS)
  `VGNC_ASSERT_IMPLY(a_finish_free, clk, rst, cmd.finish, sts.out_free)

endmodule

### src/vgnc_datapath.sv
// Datapath: extent registers, item registers, address generation, cell store, result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vgnc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  vgnc_pkg::cmd_t       cmd,
  output vgnc_pkg::sts_t       sts,
  input  vgnc_pkg::mode_t      mode,
  input  vgnc_pkg::coord_t     coord_x,
  input  vgnc_pkg::coord_t     coord_y,
  input  vgnc_pkg::coord_t     coord_z,
  input  vgnc_pkg::value_t     write_value,
  vgnc_cfg_if.sink             cfg,
  vgnc_result_if.source        result_out
);

  // Extent registers
  vgnc_pkg::cfg_data_t grid_width;
  vgnc_pkg::cfg_data_t grid_height;
  vgnc_pkg::cfg_data_t grid_depth;

  // Item registers
  vgnc_pkg::mode_t     mode_q;
  vgnc_pkg::coord_t    cx;
  vgnc_pkg::coord_t    cy;
  vgnc_pkg::coord_t    cz;
  vgnc_pkg::value_t    wv;

  // Extents latched per item
  vgnc_pkg::ext_t      ext_w;
  vgnc_pkg::ext_t      ext_h;
  vgnc_pkg::ext_t      ext_d;
  vgnc_pkg::hd_t       plane;

  // Probe
  vgnc_pkg::wcoord_t   nx;
  vgnc_pkg::wcoord_t   ny;
  vgnc_pkg::wcoord_t   nz;
  logic                probe_inside;
  logic [vgnc_pkg::SUM_W-1:0] addr_sum;
  vgnc_pkg::addr_t     probe_addr;
  logic                pend;
  logic                pend_inside;
  logic                occupied;

  // Memory
  vgnc_pkg::addr_t     clr_cnt;
  logic                ram_we;
  vgnc_pkg::addr_t     ram_addr;
  logic [vgnc_pkg::VALUE_BITS-1:0] ram_wdata;
  logic [vgnc_pkg::VALUE_BITS-1:0] ram_rdata;
  vgnc_pkg::cell_t     cell_rd;

  // Result
  vgnc_pkg::value_t    res_read;
  vgnc_pkg::count_t    res_cnt;
  logic                res_oor;
  logic                out_valid;

  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= '0;
      grid_height <= '0;
      grid_depth  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        vgnc_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data;
        vgnc_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data;
        vgnc_pkg::REG_GRID_DEPTH:  grid_depth  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Item capture and per-item extents
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      cx     <= coord_x;
      cy     <= coord_y;
      cz     <= coord_z;
      wv     <= write_value;
    end
    if (cmd.setup) begin
      ext_w <= vgnc_pkg::clamp_extent(grid_width);
      ext_h <= vgnc_pkg::clamp_extent(grid_height);
      ext_d <= vgnc_pkg::clamp_extent(grid_depth);
      plane <= vgnc_pkg::HD_W'(vgnc_pkg::clamp_extent(grid_height))
             * vgnc_pkg::HD_W'(vgnc_pkg::clamp_extent(grid_depth));
    end
  end

  // Neighbor coordinate of the current probe
  always_comb begin
    nx = vgnc_pkg::WIDE_W'(cx);
    ny = vgnc_pkg::WIDE_W'(cy);
    nz = vgnc_pkg::WIDE_W'(cz);
    if (mode_q == vgnc_pkg::MODE_COUNT) begin
      case (cmd.probe)
        vgnc_pkg::PROBE_X_MINUS: nx = nx - 7'sd1;
        vgnc_pkg::PROBE_X_PLUS:  nx = nx + 7'sd1;
        vgnc_pkg::PROBE_Y_MINUS: ny = ny - 7'sd1;
        vgnc_pkg::PROBE_Y_PLUS:  ny = ny + 7'sd1;
        vgnc_pkg::PROBE_Z_MINUS: nz = nz - 7'sd1;
        vgnc_pkg::PROBE_Z_PLUS:  nz = nz + 7'sd1;
        default: ;
      endcase
    end
  end

  // Bounds check and dense address x*H*D + y*D + z
  assign probe_inside = !nx[vgnc_pkg::WIDE_W-1] && !ny[vgnc_pkg::WIDE_W-1]
                     && !nz[vgnc_pkg::WIDE_W-1]
                     && ($unsigned(nx) < vgnc_pkg::WIDE_W'(ext_w))
                     && ($unsigned(ny) < vgnc_pkg::WIDE_W'(ext_h))
                     && ($unsigned(nz) < vgnc_pkg::WIDE_W'(ext_d));

  assign addr_sum = vgnc_pkg::SUM_W'(nx[vgnc_pkg::IDX_W-1:0]) * vgnc_pkg::SUM_W'(plane)
                  + vgnc_pkg::SUM_W'(ny[vgnc_pkg::IDX_W-1:0]) * vgnc_pkg::SUM_W'(ext_d)
                  + vgnc_pkg::SUM_W'(nz[vgnc_pkg::IDX_W-1:0]);
  assign probe_addr = vgnc_pkg::ADDR_W'(addr_sum);

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Memory port: clear sweep, else the current probe
  assign ram_we    = cmd.clear
                  || (cmd.access && (mode_q == vgnc_pkg::MODE_WRITE) && probe_inside);
  assign ram_addr  = cmd.clear ? clr_cnt : probe_addr;
  assign ram_wdata = cmd.clear ? '0 : vgnc_pkg::cell_t'(wv);

  vgnc_ram #(
    .WIDTH (vgnc_pkg::VALUE_BITS),
    .DEPTH (vgnc_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cell_rd  = vgnc_pkg::cell_t'(ram_rdata);
  assign occupied = (cell_rd != '0) && !cell_rd[vgnc_pkg::VALUE_BITS-1];

  // Reads in flight: data returns in the cycle after the address
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.access && ((mode_q == vgnc_pkg::MODE_READ)
                          || (mode_q == vgnc_pkg::MODE_COUNT));
    end
    pend_inside <= probe_inside;
  end

  // Result accumulation
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      res_read <= '0;
      res_cnt  <= '0;
      res_oor  <= 1'b0;
    end else begin
      if (cmd.access && (mode_q == vgnc_pkg::MODE_WRITE)) begin
        res_oor <= !probe_inside;
      end
      if (pend && (mode_q == vgnc_pkg::MODE_READ)) begin
        res_read <= pend_inside ? 16'(cell_rd) : '0;
      end
      if (pend && (mode_q == vgnc_pkg::MODE_COUNT) && pend_inside && occupied) begin
        res_cnt <= res_cnt + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      result_out.read_value     <= res_read;
      result_out.neighbor_count <= res_cnt;
      result_out.out_of_range   <= res_oor;
    end
  end

  assign result_out.valid = out_valid;

  assign sts.clear_last = (clr_cnt == '1);
  assign sts.out_free   = !out_valid || result_out.ready;
  assign sts.mode_count = (mode_q == vgnc_pkg::MODE_COUNT);

  `VGNC_ASSERT_IMPLY(a_count_max, clk, rst, out_valid, result_out.neighbor_count <= 3'(vgnc_pkg::NUM_PROBES))
  `VGNC_ASSERT_IMPLY(a_oor_alone, clk, rst, out_valid && result_out.out_of_range, (result_out.neighbor_count == '0) && (result_out.read_value == '0))
  `VGNC_ASSERT_IMPLY(a_write_inside, clk, rst, ram_we && !cmd.clear, probe_inside && (mode_q == vgnc_pkg::MODE_WRITE))

endmodule

### src/voxel_grid_neighbor_count.sv
// Top level of the voxel grid store with face neighbor counting.
`timescale 1ns / 1ps
// A 16x16x16 store of signed 16-bit cells, addressed densely as x*H*D + y*D + z under
// the configured extents; each item writes, reads or counts occupied face neighbors
// and returns one result. After reset the cell memory is swept to zero, one cell a
// cycle, during which no item is taken (register writes are taken). An item then
// steps the controller through setup, access, drain and finish: one access for a
// write, a read or an unused mode, six for a neighbor count, the six reads one after
// another through the single port of the cell memory. A result register sits on the
// output, so the next item is accepted while a result waits to be taken.
module voxel_grid_neighbor_count (
  input  logic          clk,
  input  logic          rst,
  vgnc_item_if.sink     item_in,
  vgnc_result_if.source result_out,
  vgnc_cfg_if.sink      cfg_wr
);

  vgnc_pkg::cmd_t cmd;
  vgnc_pkg::sts_t sts;

  vgnc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_in.valid),
    .item_ready (item_in.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vgnc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (item_in.mode),
    .coord_x     (item_in.coord_x),
    .coord_y     (item_in.coord_y),
    .coord_z     (item_in.coord_z),
    .write_value (item_in.write_value),
    .cfg         (cfg_wr),
    .result_out  (result_out)
  );

endmodule

### tb/tb_voxel_grid_neighbor_count.sv
// Self-checking testbench for the voxel grid store with face neighbor counting.
`timescale 1ns / 1ps
module tb_voxel_grid_neighbor_count;
  import vgnc_pkg::*;

  localparam mode_t MODE_UNUSED   = 2'd3;
  localparam int    TARGET_ITEMS  = 1825;
  localparam int    SETTLE_CYCLES = 16;
  localparam int    TAIL_CYCLES   = 40;
  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    MAX_REPORTS   = 40;

  typedef enum {OP_ITEM, OP_CFG, OP_SETTLE} op_kind_e;

  // One planned step: an item, a register write, or a wait for the grid to go idle
  typedef struct {
    op_kind_e   kind;
    mode_t      mode;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    value_t     wval;
    cfg_index_t reg_idx;
    cfg_data_t  reg_val;
  } plan_op_t;

  typedef struct {
    value_t read_value;
    count_t neighbor_count;
    logic   out_of_range;
  } grid_answer_t;

  logic clk;
  logic rst;

  vgnc_item_if   item_ch ();
  vgnc_result_if result_ch ();
  vgnc_cfg_if    cfg_ch ();

  voxel_grid_neighbor_count dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch),
    .cfg_wr     (cfg_ch)
  );

  // Shadow copy of the grid and its extent registers
  cell_t     shadow_cells [CELL_COUNT];
  cfg_data_t shadow_ext [3];

  plan_op_t     stim_plan [$];
  grid_answer_t answers_due [$];
  plan_op_t     item_in_flight;
  plan_op_t     cfg_in_flight;

  int planned_items;
  int items_launched;
  int results_seen;
  int send_gap;
  int recv_stall;
  int settle_cnt;
  int cycle_count;
  int mismatch_count;
  int n_write, n_read, n_count, n_unused, n_oor, n_busy_count, n_cfg;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic int eff_extent(input cfg_data_t v);
    return (int'(v) > MAX_EXTENT) ? MAX_EXTENT : int'(v);
  endfunction

  // Dense address under the current extents; 0 when the cell lies outside
  function automatic bit cell_index(input int x, input int y, input int z, output int addr);
    int w, h, d;
    w = eff_extent(shadow_ext[REG_GRID_WIDTH]);
    h = eff_extent(shadow_ext[REG_GRID_HEIGHT]);
    d = eff_extent(shadow_ext[REG_GRID_DEPTH]);
    addr = 0;
    if (x < 0 || x >= w || y < 0 || y >= h || z < 0 || z >= d) return 1'b0;
    addr = x * h * d + y * d + z;
    return 1'b1;
  endfunction

  function automatic int face_full(input int x, input int y, input int z);
    int a;
    if (!cell_index(x, y, z, a)) return 0;
    return (shadow_cells[a] > 0) ? 1 : 0;
  endfunction

  // Expected result of one accepted item; writes update the shadow grid
  function automatic grid_answer_t answer_item(input plan_op_t op);
    grid_answer_t r;
    int x, y, z, a, sum;
    r.read_value = '0;
    r.neighbor_count = '0;
    r.out_of_range = 1'b0;
    x = int'(op.x);
    y = int'(op.y);
    z = int'(op.z);
    case (op.mode)
      MODE_WRITE: begin
        if (cell_index(x, y, z, a)) shadow_cells[a] = op.wval;
        else r.out_of_range = 1'b1;
      end
      MODE_READ: begin
        if (cell_index(x, y, z, a)) r.read_value = shadow_cells[a];
      end
      MODE_COUNT: begin
        sum = face_full(x - 1, y, z) + face_full(x + 1, y, z)
            + face_full(x, y - 1, z) + face_full(x, y + 1, z)
            + face_full(x, y, z - 1) + face_full(x, y, z + 1);
        r.neighbor_count = count_t'(sum);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Item source: launches planned steps, predicts each item on its transfer
  always @(posedge clk) begin
    plan_op_t op;
    grid_answer_t ans;
    bit item_go, cfg_go;
    if (rst) begin
      item_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      send_gap = 0;
      settle_cnt = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        ans = answer_item(item_in_flight);
        answers_due.push_back(ans);
        case (item_in_flight.mode)
          MODE_WRITE: n_write++;
          MODE_READ:  n_read++;
          MODE_COUNT: n_count++;
          default:    n_unused++;
        endcase
        if (ans.out_of_range) n_oor++;
        if (ans.neighbor_count != 0) n_busy_count++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        shadow_ext[cfg_in_flight.reg_idx] = cfg_in_flight.reg_val;
        n_cfg++;
      end
      if (!(item_ch.valid && !item_ch.ready) && !(cfg_ch.valid && !cfg_ch.ready)) begin
        item_go = 1'b0;
        cfg_go = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_plan.size() != 0) begin
          op = stim_plan[0];
          case (op.kind)
            OP_SETTLE: begin
              if (answers_due.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                void'(stim_plan.pop_front());
                settle_cnt = 0;
              end else begin
                settle_cnt++;
              end
            end
            OP_CFG: begin
              void'(stim_plan.pop_front());
              cfg_ch.index <= op.reg_idx;
              cfg_ch.data <= op.reg_val;
              cfg_in_flight = op;
              cfg_go = 1'b1;
            end
            default: begin
              void'(stim_plan.pop_front());
              item_ch.mode <= op.mode;
              item_ch.coord_x <= op.x;
              item_ch.coord_y <= op.y;
              item_ch.coord_z <= op.z;
              item_ch.write_value <= op.wval;
              item_in_flight = op;
              item_go = 1'b1;
              items_launched++;
              send_gap = draw_wait(((items_launched / 80) % 5) == 4);
            end
          endcase
        end
        item_ch.valid <= item_go;
        cfg_ch.valid <= cfg_go;
      end
    end
  end

  // Result sink: random stalls, field-by-field compare against the oldest answer
  always @(posedge clk) begin
    grid_answer_t want;
    bit take;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing awaited", results_seen));
        end else begin
          want = answers_due.pop_front();
          if (result_ch.read_value !== want.read_value)
            flag_mismatch($sformatf("result %0d read_value %0d, want %0d", results_seen,
                                    result_ch.read_value, want.read_value));
          if (result_ch.neighbor_count !== want.neighbor_count)
            flag_mismatch($sformatf("result %0d neighbor_count %0d, want %0d", results_seen,
                                    result_ch.neighbor_count, want.neighbor_count));
          if (result_ch.out_of_range !== want.out_of_range)
            flag_mismatch($sformatf("result %0d out_of_range %0b, want %0b", results_seen,
                                    result_ch.out_of_range, want.out_of_range));
        end
        recv_stall = draw_wait(((results_seen / 80) % 5) == 2);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      result_ch.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still due", cycle_count,
               answers_due.size());
      $display("voxel_grid_neighbor_count: mismatch");
      $finish;
    end
  end

  task automatic push_item(input mode_t m, input int x, input int y, input int z,
                           input int v);
    plan_op_t op;
    op.kind = OP_ITEM;
    op.mode = m;
    op.x = coord_t'(x);
    op.y = coord_t'(y);
    op.z = coord_t'(z);
    op.wval = value_t'(v);
    op.reg_idx = REG_GRID_WIDTH;
    op.reg_val = '0;
    stim_plan.push_back(op);
    planned_items++;
  endtask

  task automatic push_settle();
    plan_op_t op;
    op.kind = OP_SETTLE;
    op.mode = MODE_WRITE;
    op.x = '0;
    op.y = '0;
    op.z = '0;
    op.wval = '0;
    op.reg_idx = REG_GRID_WIDTH;
    op.reg_val = '0;
    stim_plan.push_back(op);
  endtask

  // Extent change: only once the grid has gone idle
  task automatic push_config(input int w, input int h, input int d);
    plan_op_t op;
    push_settle();
    op = stim_plan[$];
    op.kind = OP_CFG;
    op.reg_idx = REG_GRID_WIDTH;
    op.reg_val = cfg_data_t'(w);
    stim_plan.push_back(op);
    op.reg_idx = REG_GRID_HEIGHT;
    op.reg_val = cfg_data_t'(h);
    stim_plan.push_back(op);
    op.reg_idx = REG_GRID_DEPTH;
    op.reg_val = cfg_data_t'(d);
    stim_plan.push_back(op);
  endtask

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 16) return $urandom_range(16, 31);
    if (r < 30) return $urandom_range(9, 16);
    return $urandom_range(1, 6);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 9);
      2:       return -int'($urandom_range(1, 9));
      3:       return 32767;
      4:       return -32768;
      default: return $urandom;
    endcase
  endfunction

  // Mostly coordinates in or just around the grid, some raw noise
  task automatic push_random_item(input int ew, input int eh, input int ed);
    int r;
    mode_t m;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_item(mode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
    end else begin
      r = $urandom_range(0, 99);
      m = (r < 40) ? MODE_WRITE : (r < 65) ? MODE_READ : MODE_COUNT;
      push_item(m, int'($urandom_range(0, ew + 1)) - 1, int'($urandom_range(0, eh + 1)) - 1,
                int'($urandom_range(0, ed + 1)) - 1, pick_value());
    end
  endtask

  initial begin
    int w, h, d, n;
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_WRITE;
    item_ch.coord_x = '0;
    item_ch.coord_y = '0;
    item_ch.coord_z = '0;
    item_ch.write_value = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GRID_WIDTH;
    cfg_ch.data = '0;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    foreach (shadow_ext[i]) shadow_ext[i] = '0;

    // Empty grid straight out of reset
    push_item(MODE_WRITE, 0, 0, 0, 7);
    push_item(MODE_READ, 0, 0, 0, 0);
    push_item(MODE_COUNT, 0, 0, 0, 0);
    push_item(MODE_UNUSED, 5, -3, 9, 1234);

    // Full grid: corners, value extremes, edge coordinates
    push_config(16, 16, 16);
    push_item(MODE_WRITE, 0, 0, 0, 32767);
    push_item(MODE_WRITE, 15, 15, 15, -32768);
    push_item(MODE_WRITE, 1, 0, 0, 1);
    push_item(MODE_WRITE, 0, 1, 0, -1);
    push_item(MODE_WRITE, 0, 0, 1, 5);
    push_item(MODE_READ, 0, 0, 0, 0);
    push_item(MODE_READ, 15, 15, 15, 0);
    push_item(MODE_READ, -32, -32, -32, 0);
    push_item(MODE_READ, 31, 31, 31, 0);
    push_item(MODE_READ, 16, 0, 0, 0);
    push_item(MODE_COUNT, 0, 0, 0, 0);
    // count centered outside the grid, one neighbor inside
    push_item(MODE_COUNT, -1, 0, 0, 0);
    // negative neighbor does not count as occupied
    push_item(MODE_COUNT, 15, 15, 14, 0);
    push_item(MODE_COUNT, 16, 15, 15, 0);
    push_item(MODE_WRITE, 16, 0, 0, 9);
    push_item(MODE_WRITE, 0, -1, 0, 9);
    push_item(MODE_WRITE, 0, 0, 16, 9);
    push_item(MODE_UNUSED, -32, 31, -1, -1);

    // Extents above the store size saturate
    push_config(31, 17, 20);
    push_item(MODE_READ, 15, 15, 15, 0);
    push_item(MODE_COUNT, 0, 0, 0, 0);

    // Smaller extents reinterpret the same addresses
    push_config(2, 3, 4);
    push_item(MODE_READ, 0, 0, 1, 0);
    push_item(MODE_COUNT, 0, 0, 0, 0);

    // Random phases, each under its own extents
    while (planned_items < TARGET_ITEMS) begin
      w = pick_extent();
      h = pick_extent();
      d = pick_extent();
      push_config(w, h, d);
      n = $urandom_range(40, 120);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 49) == 0) push_settle();
        push_random_item((w > MAX_EXTENT) ? MAX_EXTENT : w, (h > MAX_EXTENT) ? MAX_EXTENT : h,
                         (d > MAX_EXTENT) ? MAX_EXTENT : d);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (stim_plan.size() != 0 || item_ch.valid || cfg_ch.valid || answers_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (answers_due.size() != 0)
      flag_mismatch($sformatf("%0d answers never arrived", answers_due.size()));

    $display("covered %0d items: %0d writes (%0d outside the grid), %0d reads, %0d counts",
             items_launched, n_write, n_oor, n_read, n_count);
    $display("plus %0d unused-mode items, %0d nonzero counts, %0d register writes",
             n_unused, n_busy_count, n_cfg);
    if (mismatch_count == 0) begin
      $display("voxel_grid_neighbor_count: match");
    end else begin
      $display("voxel_grid_neighbor_count: mismatch");
    end
    $finish;
  end

endmodule
